/* rtl/core/cwc_pkg.sv */
// ----------------------------------------------------------------------------
// Coin-change way counter: shared package
// Widths, reset values, sequencer states and the control structures that
// pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cwc_pkg;

	// Field and register widths.
	localparam int AMT_W      = 10;
	localparam int COIN_W     = 10;
	localparam int COIN_REGS  = 8;
	localparam int COIN_IDX_W = 3;
	localparam int WAYS_W     = 63;

	// Counts saturate at the largest value that the result field holds.
	localparam logic [WAYS_W-1:0] WAYS_LIMIT = '1;

	// Default sizing of the top level.
	localparam int DEF_NUM_COINS  = 8;
	localparam int DEF_MAX_AMOUNT = 1023;

	// Reset values of the coin registers, register 7 first.
	localparam logic [COIN_REGS-1:0][COIN_W-1:0] COIN_RESET = {
		10'd200, 10'd100, 10'd50, 10'd20, 10'd10, 10'd5, 10'd2, 10'd1
	};

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_COIN,
		ST_SWEEP,
		ST_FETCH,
		ST_RESULT
	} seq_state_t;

	// Table command from the sequencer.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_sum;
		logic wr_one;
	} tbl_cmd_t;

	// Query status from the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
		logic oor;
	} seq_stat_t;

endpackage

/* rtl/core/coin_change_way_counter.sv */
// ----------------------------------------------------------------------------
// Coin-change way counter
// Counts the unordered ways to form a target amount from up to eight
// configurable coin denominations, with counts saturating at 2^63 - 1.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                          Transfer
// config    in         cfg_we, cfg_index, cfg_data      cfg_we high
// query     in         start, amount                    start high, busy low
// result    out        done, ways, saturated            done high, one cycle
//
// The single write port of the way table sets the pace of a query: one
// entry is cleared or updated per cycle. An amount above MAX_AMOUNT returns
// its result in the next cycle.
// Reset restores the coin registers and leaves the table content undefined;
// every query clears the entries it reads. The result is not held: done is
// high for one cycle, and busy stays high until then.
// ----------------------------------------------------------------------------
module coin_change_way_counter #(
	parameter int NUM_COINS  = cwc_pkg::DEF_NUM_COINS,
	parameter int MAX_AMOUNT = cwc_pkg::DEF_MAX_AMOUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cwc_pkg::COIN_IDX_W-1:0]   cfg_index,
	input  logic [cwc_pkg::COIN_W-1:0]       cfg_data,
	input  logic                             start,
	input  logic [cwc_pkg::AMT_W-1:0]        amount,
	output logic                             busy,
	output logic                             done,
	output logic [cwc_pkg::WAYS_W-1:0]       ways,
	output logic                             saturated
);

	localparam int AW = $clog2(MAX_AMOUNT + 1);

	logic [cwc_pkg::COIN_REGS-1:0][cwc_pkg::COIN_W-1:0] coin_q;
	logic                                               sat_q;
	cwc_pkg::tbl_cmd_t                                  cmd;
	cwc_pkg::seq_stat_t                                 stat;
	logic [AW-1:0]                                      rd_addr_a;
	logic [AW-1:0]                                      rd_addr_b;
	logic [AW-1:0]                                      wr_addr;
	logic [cwc_pkg::WAYS_W-1:0]                         wr_data;
	logic [cwc_pkg::WAYS_W-1:0]                         rd_data_a;
	logic [cwc_pkg::WAYS_W-1:0]                         rd_data_b;
	logic [cwc_pkg::WAYS_W-1:0]                         sum;
	logic                                               add_sat;
	logic                                               accept;

	// Coin denomination registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_q <= cwc_pkg::COIN_RESET;
		end else if (cfg_we) begin
			coin_q[cfg_index] <= cfg_data;
		end
	end

	// Query transfer.
	assign accept = start && !stat.busy;

	// Saturation flag of the current query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (accept) begin
			sat_q <= 1'b0;
		end else if (cmd.wr_en && cmd.wr_sum && add_sat) begin
			sat_q <= 1'b1;
		end
	end

	cwc_seq #(
		.NUM_COINS  (NUM_COINS),
		.MAX_AMOUNT (MAX_AMOUNT),
		.AW         (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.amount    (amount),
		.coins     (coin_q),
		.cmd       (cmd),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_addr   (wr_addr),
		.stat      (stat)
	);

	cwc_table #(
		.DEPTH (MAX_AMOUNT + 1),
		.AW    (AW)
	) u_table (
		.clk       (clk),
		.rd_en     (cmd.rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_en     (cmd.wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	cwc_sat_add u_add (
		.a   (rd_data_a),
		.b   (rd_data_b),
		.sum (sum),
		.sat (add_sat)
	);

	// Table write data: the seed pattern while clearing, else the sum.
	always_comb begin
		if (cmd.wr_sum) begin
			wr_data = sum;
		end else begin
			wr_data = {{(cwc_pkg::WAYS_W-1){1'b0}}, cmd.wr_one};
		end
	end

	// Result ports.
	assign busy      = stat.busy;
	assign done      = stat.done;
	assign ways      = stat.oor ? '0 : rd_data_a;
	assign saturated = sat_q;

`ifndef SYNTH
	// A transferred query keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("query transfer did not start the sequencer");

	// The saturation flag starts clear for every query.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !saturated)
		else $error("saturation flag not cleared at query start");

	// An out-of-range query never writes to the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy && stat.oor) |-> !cmd.wr_en)
		else $error("table written during out-of-range query");
`endif

endmodule

/* rtl/core/cwc_sat_add.sv */
// ----------------------------------------------------------------------------
// Coin-change way counter: saturating adder
// The one adder of the table datapath. It adds two table entries and clamps
// the sum at the count limit, flagging every sum that reaches the limit.
// ----------------------------------------------------------------------------
module cwc_sat_add (
	input  logic [cwc_pkg::WAYS_W-1:0] a,
	input  logic [cwc_pkg::WAYS_W-1:0] b,
	output logic [cwc_pkg::WAYS_W-1:0] sum,
	output logic                       sat
);

	logic [cwc_pkg::WAYS_W:0] raw;

	// Both operands are at most the limit, so the wide sum never wraps.
	always_comb begin
		raw = {1'b0, a} + {1'b0, b};
		sat = (raw >= {1'b0, cwc_pkg::WAYS_LIMIT});
		sum = sat ? cwc_pkg::WAYS_LIMIT : raw[cwc_pkg::WAYS_W-1:0];
	end

endmodule

/* rtl/core/cwc_table.sv */
// ----------------------------------------------------------------------------
// Coin-change way counter: way table
// Scratch memory with one write port and two registered read ports. A read
// of the address being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module cwc_table #(
	parameter int DEPTH = cwc_pkg::DEF_MAX_AMOUNT + 1,
	parameter int AW    = $clog2(cwc_pkg::DEF_MAX_AMOUNT + 1)
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr_a,
	input  logic [AW-1:0]              rd_addr_b,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [cwc_pkg::WAYS_W-1:0] wr_data,
	output logic [cwc_pkg::WAYS_W-1:0] rd_data_a,
	output logic [cwc_pkg::WAYS_W-1:0] rd_data_b
);

	logic [cwc_pkg::WAYS_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read ports with write-first bypass.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr_a)) begin
				rd_data_a <= wr_data;
			end else begin
				rd_data_a <= mem[rd_addr_a];
			end
			if (wr_en && (wr_addr == rd_addr_b)) begin
				rd_data_b <= wr_data;
			end else begin
				rd_data_b <= mem[rd_addr_b];
			end
		end
	end

endmodule

/* rtl/core/cwc_seq.sv */
// ----------------------------------------------------------------------------
// Coin-change way counter: sequencer
// Steps one query through the table: a clearing pass, one sweep per coin
// with a one-deep read/add/write pipeline, and a final fetch of the answer.
// ----------------------------------------------------------------------------
module cwc_seq #(
	parameter int NUM_COINS  = cwc_pkg::DEF_NUM_COINS,
	parameter int MAX_AMOUNT = cwc_pkg::DEF_MAX_AMOUNT,
	parameter int AW         = $clog2(cwc_pkg::DEF_MAX_AMOUNT + 1)
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                start,
	input  logic [cwc_pkg::AMT_W-1:0]                           amount,
	input  logic [cwc_pkg::COIN_REGS-1:0][cwc_pkg::COIN_W-1:0]  coins,
	output cwc_pkg::tbl_cmd_t                                   cmd,
	output logic [AW-1:0]                                       rd_addr_a,
	output logic [AW-1:0]                                       rd_addr_b,
	output logic [AW-1:0]                                       wr_addr,
	output cwc_pkg::seq_stat_t                                  stat
);

	localparam int KW = $clog2(NUM_COINS + 1);

	cwc_pkg::seq_state_t state_q, state_d;

	logic [AW-1:0]                     amt_q;
	logic [AW-1:0]                     s_q;
	logic [AW-1:0]                     b_q;
	logic [KW-1:0]                     k_q;
	logic                              oor_q;
	logic                              v_s1;
	logic [AW-1:0]                     waddr_s1;
	logic [cwc_pkg::COIN_IDX_W-1:0]    coin_idx;
	logic [cwc_pkg::COIN_W-1:0]        coin_val;
	logic                              coin_skip;
	logic                              last_coin;
	logic                              at_end;
	logic                              oor_in;

	// Coin selection and loop-end tests.
	always_comb begin
		coin_idx  = cwc_pkg::COIN_IDX_W'(k_q);
		coin_val  = coins[coin_idx];
		coin_skip = (coin_val == '0) || (32'(coin_val) > 32'(amt_q));
		last_coin = (32'(k_q) == 32'(NUM_COINS));
		at_end    = (s_q == amt_q);
		oor_in    = (32'(amount) > 32'(MAX_AMOUNT));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cwc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = oor_in ? cwc_pkg::ST_RESULT : cwc_pkg::ST_CLEAR;
				end
			end
			cwc_pkg::ST_CLEAR: begin
				if (at_end) begin
					state_d = cwc_pkg::ST_COIN;
				end
			end
			cwc_pkg::ST_COIN: begin
				if (last_coin) begin
					state_d = cwc_pkg::ST_FETCH;
				end else if (!coin_skip) begin
					state_d = cwc_pkg::ST_SWEEP;
				end
			end
			cwc_pkg::ST_SWEEP: begin
				if (at_end) begin
					state_d = cwc_pkg::ST_COIN;
				end
			end
			cwc_pkg::ST_FETCH:  state_d = cwc_pkg::ST_RESULT;
			cwc_pkg::ST_RESULT: state_d = cwc_pkg::ST_IDLE;
			default:            state_d = cwc_pkg::ST_IDLE;
		endcase
	end

	// Outputs: table command, addresses and status.
	always_comb begin
		cmd       = '0;
		rd_addr_a = s_q;
		rd_addr_b = b_q;
		wr_addr   = waddr_s1;
		stat.busy = (state_q != cwc_pkg::ST_IDLE);
		stat.done = 1'b0;
		stat.oor  = oor_q;
		case (state_q)
			cwc_pkg::ST_CLEAR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_one = (s_q == '0);
				wr_addr    = s_q;
			end
			cwc_pkg::ST_SWEEP: begin
				cmd.rd_en = 1'b1;
			end
			cwc_pkg::ST_FETCH: begin
				cmd.rd_en = 1'b1;
				rd_addr_a = amt_q;
			end
			cwc_pkg::ST_RESULT: begin
				stat.done = 1'b1;
			end
			default: begin
			end
		endcase
		// The sweep write lands in the cycle after its reads.
		if (v_s1) begin
			cmd.wr_en  = 1'b1;
			cmd.wr_sum = 1'b1;
		end
	end

	// State and pipeline valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cwc_pkg::ST_IDLE;
			v_s1    <= 1'b0;
			k_q     <= '0;
			oor_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == cwc_pkg::ST_SWEEP);
			if ((state_q == cwc_pkg::ST_IDLE) && start) begin
				k_q   <= '0;
				oor_q <= oor_in;
			end else if ((state_q == cwc_pkg::ST_COIN) && !last_coin) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Sweep counters: s runs over the target entry, b lags it by the coin.
	always_ff @(posedge clk) begin
		waddr_s1 <= s_q;
		case (state_q)
			cwc_pkg::ST_IDLE: begin
				if (start) begin
					amt_q <= AW'(amount);
					s_q   <= '0;
				end
			end
			cwc_pkg::ST_CLEAR: begin
				s_q <= s_q + 1'b1;
			end
			cwc_pkg::ST_COIN: begin
				s_q <= AW'(coin_val);
				b_q <= '0;
			end
			cwc_pkg::ST_SWEEP: begin
				s_q <= s_q + 1'b1;
				b_q <= b_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	// Every table write stays inside the range of the current query.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (wr_addr <= amt_q))
		else $error("table write beyond query amount");

	// During a sweep the source entry lies strictly below the target entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cwc_pkg::ST_SWEEP) |-> (rd_addr_b < rd_addr_a))
		else $error("sweep source does not lag target");

	// A result transfer ends the query.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> !stat.busy)
		else $error("sequencer still busy after result");
`endif

endmodule

/* tb/tb_coin_change_way_counter.sv */
// ----------------------------------------------------------------------------
// Testbench: coin-change way counter
// Sends target amounts under several coin settings and checks every result
// strobe against a software count of the unordered coin combinations. The
// directed tests cover the reset coins, unit coins, zero coins, coins larger
// than the amount and the extreme amounts. Random queries follow, with
// sender idling.
// ----------------------------------------------------------------------------
module tb_coin_change_way_counter;

	localparam int NUM_COINS      = cwc_pkg::DEF_NUM_COINS;
	localparam int MAX_AMOUNT     = cwc_pkg::DEF_MAX_AMOUNT;
	localparam int TW             = $clog2(MAX_AMOUNT + 1);
	localparam int STALL_LIMIT    = 60000;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_QUERIES  = 20;

	typedef logic [cwc_pkg::COIN_REGS-1:0][cwc_pkg::COIN_W-1:0] coin_set_t;

	// One expected query result, with its amount kept for reporting.
	typedef struct {
		logic [cwc_pkg::AMT_W-1:0]  amount;
		logic [cwc_pkg::WAYS_W-1:0] ways;
		logic                       sat;
	} way_count_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [cwc_pkg::COIN_IDX_W-1:0] cfg_index = '0;
	logic [cwc_pkg::COIN_W-1:0]     cfg_data  = '0;
	logic                           start     = 1'b0;
	logic [cwc_pkg::AMT_W-1:0]      amount    = '0;
	logic                           busy;
	logic                           done;
	logic [cwc_pkg::WAYS_W-1:0]     ways;
	logic                           saturated;

	// Coin registers as the block should hold them.
	logic [cwc_pkg::COIN_W-1:0] coin_reg [cwc_pkg::COIN_REGS];

	way_count_t                 pending_counts [$];
	int                         mismatches      = 0;
	int                         unexpected      = 0;
	int                         queries_sent    = 0;
	int                         results_checked = 0;
	int                         coin_settings   = 0;
	int                         sat_results     = 0;
	int                         stall_cycles    = 0;
	int                         last_amount     = 0;
	bit                         no_idle         = 1'b0;
	logic [cwc_pkg::WAYS_W-1:0] largest_count   = '0;

	coin_change_way_counter #(
		.NUM_COINS (NUM_COINS),
		.MAX_AMOUNT(MAX_AMOUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.start    (start),
		.amount   (amount),
		.busy     (busy),
		.done     (done),
		.ways     (ways),
		.saturated(saturated)
	);

	// Clock with a period of 10.
	always #5 clk = ~clk;

	// Counts the coin combinations for one amount on a rolling table,
	// saturating every addition at the largest result value.
	function automatic void count_ways(input logic [cwc_pkg::AMT_W-1:0] amt,
			output logic [cwc_pkg::WAYS_W-1:0] total, output logic sat);
		logic [63:0] partial [MAX_AMOUNT+1];
		logic [63:0] sum;
		int          c;
		total = '0;
		sat   = 1'b0;
		if (int'(amt) > MAX_AMOUNT)
			return;
		for (int s = 0; s <= int'(amt); s++)
			partial[TW'(s)] = '0;
		partial[0] = 64'd1;
		for (int k = 0; k < NUM_COINS && k < cwc_pkg::COIN_REGS; k++) begin
			c = int'(coin_reg[cwc_pkg::COIN_IDX_W'(k)]);
			// A zero coin adds no way and is skipped.
			if (c == 0)
				continue;
			for (int s = c; s <= int'(amt); s++) begin
				sum = partial[TW'(s)] + partial[TW'(s - c)];
				if (sum >= {1'b0, cwc_pkg::WAYS_LIMIT}) begin
					sat = 1'b1;
					sum = {1'b0, cwc_pkg::WAYS_LIMIT};
				end
				partial[TW'(s)] = sum;
			end
		end
		total = partial[TW'(amt)][cwc_pkg::WAYS_W-1:0];
	endfunction

	// Writes all coin registers, one per cycle, and tracks the new values.
	task automatic load_coins(input coin_set_t coins);
		for (int i = 0; i < cwc_pkg::COIN_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cwc_pkg::COIN_IDX_W'(i);
			cfg_data  <= coins[cwc_pkg::COIN_IDX_W'(i)];
			@(posedge clk);
			coin_reg[cwc_pkg::COIN_IDX_W'(i)] = coins[cwc_pkg::COIN_IDX_W'(i)];
		end
		cfg_we <= 1'b0;
		coin_settings++;
	endtask

	// Offers one amount and holds it until the transfer; start stays high
	// so that a following query can go out back to back.
	task automatic send_amount(input logic [cwc_pkg::AMT_W-1:0] amt);
		way_count_t next_count;
		start  <= 1'b1;
		amount <= amt;
		do
			@(posedge clk);
		while (busy);
		next_count.amount = amt;
		count_ways(amt, next_count.ways, next_count.sat);
		pending_counts.push_back(next_count);
		queries_sent++;
		last_amount = int'(amt);
	endtask

	// Random sender gap: mostly short, sometimes as long as a query so that
	// the gap ends in any phase of the block's work.
	task automatic sender_pause();
		int gap;
		if (no_idle || $urandom_range(0, 99) >= 33)
			return;
		if ($urandom_range(0, 1) == 0)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(1, 9 * (last_amount + 1) + 16);
		start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Waits until every outstanding result has arrived and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_counts.size() != 0 || busy)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Reset coins: extremes of the amount and each bit of it both ways.
	task automatic test_default_coins();
		logic [cwc_pkg::AMT_W-1:0] amounts [11] = '{0, 1, 2, 5, 10, 100, 200,
			341, 682, 512, 1023};
		foreach (amounts[i])
			send_amount(amounts[i]);
		drain();
	endtask

	// All coins of value one: the largest counts the block can produce.
	task automatic test_unit_coins();
		load_coins({cwc_pkg::COIN_REGS{cwc_pkg::COIN_W'(1)}});
		send_amount(cwc_pkg::AMT_W'(0));
		send_amount(cwc_pkg::AMT_W'(7));
		send_amount(cwc_pkg::AMT_W'(1023));
		drain();
	endtask

	// Zero coins mixed with coins larger than most amounts.
	task automatic test_zero_and_large_coins();
		load_coins({10'd0, 10'd1023, 10'd0, 10'd3, 10'd1023, 10'd0, 10'd7, 10'd512});
		send_amount(cwc_pkg::AMT_W'(3));
		send_amount(cwc_pkg::AMT_W'(21));
		send_amount(cwc_pkg::AMT_W'(600));
		send_amount(cwc_pkg::AMT_W'(1023));
		drain();
	endtask

	// No usable coin: only the zero amount has a way.
	task automatic test_no_usable_coins();
		load_coins('0);
		send_amount(cwc_pkg::AMT_W'(0));
		send_amount(cwc_pkg::AMT_W'(5));
		drain();
	endtask

	// Random coin sets and amounts, mostly small amounts to keep the run short.
	task automatic test_random_queries();
		coin_set_t                 coins;
		logic [cwc_pkg::AMT_W-1:0] amt;
		int                        pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				coins = cwc_pkg::COIN_RESET;
			end else begin
				foreach (coins[i]) begin
					pick = $urandom_range(0, 99);
					if (pick < 50)
						coins[i] = cwc_pkg::COIN_W'($urandom_range(1, 20));
					else if (pick < 65)
						coins[i] = cwc_pkg::COIN_W'($urandom_range(21, 1023));
					else if (pick < 80)
						coins[i] = '0;
					else if (pick < 90)
						coins[i] = '1;
					else
						coins[i] = cwc_pkg::COIN_W'(1);
				end
			end
			load_coins(coins);
			// One phase runs back to back with no sender gaps.
			no_idle = (phase == 2);
			for (int n = 0; n < PHASE_QUERIES; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					amt = cwc_pkg::AMT_W'($urandom_range(0, 127));
				else if (pick < 95)
					amt = cwc_pkg::AMT_W'($urandom_range(0, 1023));
				else
					amt = cwc_pkg::AMT_W'($urandom_range(960, 1023));
				send_amount(amt);
				sender_pause();
			end
			drain();
		end
		no_idle = 1'b0;
	endtask

	// Result checker: each strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		way_count_t want;
		if (arst_n && done) begin
			if (pending_counts.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= MAX_REPORTS)
					$display("Result with no query outstanding: ways=%0d saturated=%0b",
						ways, saturated);
			end else begin
				want = pending_counts.pop_front();
				results_checked++;
				if (ways !== want.ways || saturated !== want.sat) begin
					mismatches++;
					if (mismatches + unexpected <= MAX_REPORTS)
						$display({"Mismatch for amount %0d: expected ways=%0d sat=%0b,",
							" got ways=%0d sat=%0b"},
							want.amount, want.ways, want.sat, ways, saturated);
				end
				if (want.sat)
					sat_results++;
				if (want.ways > largest_count)
					largest_count = want.ways;
			end
		end
	end

	// Watchdog on cycles with no transfer of any kind.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Test sequence.
	initial begin
		foreach (coin_reg[i])
			coin_reg[i] = cwc_pkg::COIN_RESET[i];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_coins();
		test_unit_coins();
		test_zero_and_large_coins();
		test_no_usable_coins();
		test_random_queries();
		repeat (16) @(posedge clk);
		$display({"Ran %0d queries under %0d loaded coin sets plus the reset set;",
			" %0d results checked."},
			queries_sent, coin_settings, results_checked);
		$display("Largest expected count %0d, saturated results %0d, %0d left outstanding.",
			largest_count, sat_results, pending_counts.size());
		if (mismatches == 0 && unexpected == 0 && pending_counts.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
